### src/stream_substring_replace_macros.svh
// Assertion macros for the stream substring replace block.
// Used by ssr_ctrl and ssr_dp; expects clk and rst in scope.
`ifndef STREAM_SUBSTRING_REPLACE_MACROS_SVH
`define STREAM_SUBSTRING_REPLACE_MACROS_SVH

// Same-cycle implication, off during reset.
`define SSR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define SSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ssr_pkg.sv
// Shared types and constants for the stream substring replace block.
// No dependencies; imported by every module of the block.
`default_nettype none

package ssr_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int REPLACE_MAX_DEF = 8;
  localparam int DATA_W          = 64;
  localparam int ADDR_W          = 5;

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    WIN_HOLD,
    WIN_INSERT,
    WIN_INSERT_POP,
    WIN_POP,
    WIN_CLEAR
  } win_op_t;

  typedef enum logic [1:0] {
    OSEL_CAND0,
    OSEL_HEAD,
    OSEL_REP,
    OSEL_MARK
  } out_sel_t;

  typedef enum logic [1:0] {
    REP_HOLD,
    REP_START,
    REP_NEXT,
    REP_CLR
  } rep_op_t;

  typedef struct packed {
    logic [63:0] pattern_bytes;
    logic [3:0]  pattern_length;
    logic [63:0] replacement_bytes;
    logic [3:0]  replacement_length;
    logic        plen_wr;
  } cfg_t;

  typedef struct packed {
    win_op_t  win_op;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
    rep_op_t  rep_op;
    logic     end_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic full;
    logic match;
    logic fill_zero;
    logic fill_one;
    logic rlen_zero;
    logic rlen_one;
    logic idx_last;
    logic end_q;
  } status_t;

endpackage

`default_nettype wire

### src/ssr_regs.sv
// APB register file for pattern and replacement settings.
// Depends on ssr_pkg for the register map and the cfg_t bundle.
`default_nettype none

module ssr_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ssr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ssr_pkg::DATA_W-1:0] pwdata,
  output logic      [ssr_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output ssr_pkg::cfg_t                   cfg
);
  import ssr_pkg::*;

  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_length;
  logic [63:0] replacement_bytes;
  logic [3:0]  replacement_length;
  logic        wr_en;
  reg_idx_t    idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= 4'd1;
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_PATTERN_BYTES:      pattern_bytes      <= pwdata;
        REG_PATTERN_LENGTH:     pattern_length     <= pwdata[3:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= pwdata;
        REG_REPLACEMENT_LENGTH: replacement_length <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PATTERN_BYTES:      prdata = pattern_bytes;
      REG_PATTERN_LENGTH:     prdata = {60'd0, pattern_length};
      REG_REPLACEMENT_BYTES:  prdata = replacement_bytes;
      REG_REPLACEMENT_LENGTH: prdata = {60'd0, replacement_length};
      default:                prdata = '0;
    endcase
  end

  // a new pattern length discards the held bytes
  assign cfg.pattern_bytes      = pattern_bytes;
  assign cfg.pattern_length     = pattern_length;
  assign cfg.replacement_bytes  = replacement_bytes;
  assign cfg.replacement_length = replacement_length;
  assign cfg.plen_wr            = wr_en && (idx == REG_PATTERN_LENGTH);

endmodule

`default_nettype wire

### src/ssr_dp.sv
// Datapath: byte window, pattern compare, replacement index and output word register.
// Depends on ssr_pkg; driven by commands from ssr_ctrl.
`default_nettype none

`include "stream_substring_replace_macros.svh"

module ssr_dp #(
  parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = ssr_pkg::REPLACE_MAX_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ssr_pkg::cfg_t    cfg,
  input  wire ssr_pkg::cmd_t    cmd,
  input  wire logic [7:0]       in_byte,
  input  wire logic             end_of_string,
  input  wire logic             result_ready,
  output ssr_pkg::status_t      status,
  output logic                  result_valid,
  output logic [7:0]            out_byte,
  output logic                  out_valid,
  output logic                  out_last
);
  import ssr_pkg::*;

  localparam int FILL_W = $clog2(PATTERN_MAX + 1);
  localparam int RIDX_W = (REPLACE_MAX > 0) ? $clog2(REPLACE_MAX + 1) : 1;

  logic [7:0]        win [PATTERN_MAX];
  logic [7:0]        cand [PATTERN_MAX];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_new;
  logic [FILL_W-1:0] plen;
  logic [RIDX_W-1:0] rlen;
  logic [RIDX_W-1:0] rep_idx;
  logic [7:0]        rep_byte;
  logic              eq;
  logic              end_q;

  // clamp lengths into the supported range
  always_comb begin
    if (cfg.pattern_length == 4'd0) begin
      plen = FILL_W'(1);
    end else if (cfg.pattern_length > 4'(PATTERN_MAX)) begin
      plen = FILL_W'(PATTERN_MAX);
    end else begin
      plen = FILL_W'(cfg.pattern_length);
    end
    if (cfg.replacement_length > 4'(REPLACE_MAX)) begin
      rlen = RIDX_W'(REPLACE_MAX);
    end else begin
      rlen = RIDX_W'(cfg.replacement_length);
    end
  end

  assign fill_new = (fill < FILL_W'(PATTERN_MAX)) ? fill + FILL_W'(1) : fill;

  // window as it looks with the incoming byte appended
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      cand[i] = (fill == FILL_W'(i)) ? in_byte : win[i];
    end
  end

  always_comb begin
    eq = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ((FILL_W'(i) < plen) && (cand[i] != cfg.pattern_bytes[8*i +: 8])) begin
        eq = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.win_op)
      WIN_INSERT: begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
          win[i] <= cand[i];
        end
      end
      WIN_INSERT_POP: begin
        for (int i = 0; i < PATTERN_MAX - 1; i++) begin
          win[i] <= cand[i+1];
        end
      end
      WIN_POP: begin
        for (int i = 0; i < PATTERN_MAX - 1; i++) begin
          win[i] <= win[i+1];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cfg.plen_wr) begin
      fill <= '0;
    end else begin
      case (cmd.win_op)
        WIN_INSERT:     fill <= fill_new;
        WIN_INSERT_POP: fill <= fill_new - FILL_W'(1);
        WIN_POP:        fill <= fill - FILL_W'(1);
        WIN_CLEAR:      fill <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_idx <= '0;
    end else begin
      case (cmd.rep_op)
        REP_START: rep_idx <= RIDX_W'(1);
        REP_NEXT:  rep_idx <= rep_idx + RIDX_W'(1);
        REP_CLR:   rep_idx <= '0;
        default: ;
      endcase
    end
  end

  always_comb begin
    rep_byte = 8'd0;
    for (int k = 0; k < REPLACE_MAX; k++) begin
      if (rep_idx == RIDX_W'(k)) begin
        rep_byte = cfg.replacement_bytes[8*k +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.end_load) begin
      end_q <= end_of_string;
    end
  end

  // output word register: loads when free, drops after the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_last <= cmd.out_last;
      case (cmd.out_sel)
        OSEL_CAND0: begin
          out_byte  <= cand[0];
          out_valid <= 1'b1;
        end
        OSEL_HEAD: begin
          out_byte  <= win[0];
          out_valid <= 1'b1;
        end
        OSEL_REP: begin
          out_byte  <= rep_byte;
          out_valid <= 1'b1;
        end
        default: begin
          out_byte  <= 8'd0;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  assign status.out_free  = !result_valid || result_ready;
  assign status.full      = fill_new >= plen;
  assign status.match     = (fill_new >= plen) && eq;
  assign status.fill_zero = fill == '0;
  assign status.fill_one  = fill == FILL_W'(1);
  assign status.rlen_zero = rlen == '0;
  assign status.rlen_one  = rlen == RIDX_W'(1);
  assign status.idx_last  = RIDX_W'(rep_idx + RIDX_W'(1)) == rlen;
  assign status.end_q     = end_q;

  `SSR_ASSERT_IMPL(a_fill_below_plen, 1'b1, fill < plen, "window fill reached pattern length")
  `SSR_ASSERT_IMPL(a_mark_zero, result_valid && !out_valid, out_byte == 8'd0, "end marker carries data")
  `SSR_ASSERT_IMPL(a_idx_range, 1'b1, (rep_idx == '0) || (rep_idx < rlen), "replacement index out of range")

endmodule

`default_nettype wire

### src/ssr_ctrl.sv
// Controller: decides per accepted word what the datapath emits, then
// sequences replacement and flush output. Depends on ssr_pkg.
`default_nettype none

`include "stream_substring_replace_macros.svh"

module ssr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire logic             carries_byte,
  input  wire logic             end_of_string,
  input  wire ssr_pkg::status_t status,
  output ssr_pkg::cmd_t         cmd,
  output logic                  item_ready
);
  import ssr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_REPL  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign item_ready = (state == ST_IDLE) && status.out_free;
  assign accept     = item_valid && item_ready;

  always_comb begin
    state_next   = state;
    cmd.win_op   = WIN_HOLD;
    cmd.out_load = 1'b0;
    cmd.out_sel  = OSEL_MARK;
    cmd.out_last = 1'b0;
    cmd.rep_op   = REP_HOLD;
    cmd.end_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.end_load = 1'b1;
          if (carries_byte) begin
            if (!status.full) begin
              cmd.win_op = WIN_INSERT;
              if (end_of_string) begin
                state_next = ST_FLUSH;
              end
            end else if (status.match) begin
              cmd.win_op = WIN_CLEAR;
              if (!status.rlen_zero) begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = OSEL_REP;
                cmd.out_last = end_of_string && status.rlen_one;
                if (!status.rlen_one) begin
                  cmd.rep_op = REP_START;
                  state_next = ST_REPL;
                end
              end else if (end_of_string) begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = OSEL_MARK;
                cmd.out_last = 1'b1;
              end
            end else begin
              // no match: release the oldest byte
              cmd.win_op   = WIN_INSERT_POP;
              cmd.out_load = 1'b1;
              cmd.out_sel  = OSEL_CAND0;
              cmd.out_last = end_of_string && status.fill_zero;
              if (end_of_string && !status.fill_zero) begin
                state_next = ST_FLUSH;
              end
            end
          end else if (end_of_string) begin
            if (status.fill_zero) begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = OSEL_MARK;
              cmd.out_last = 1'b1;
            end else begin
              state_next = ST_FLUSH;
            end
          end
        end
      end
      ST_REPL: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_REP;
          cmd.out_last = status.end_q && status.idx_last;
          if (status.idx_last) begin
            cmd.rep_op = REP_CLR;
            state_next = ST_IDLE;
          end else begin
            cmd.rep_op = REP_NEXT;
          end
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.win_op   = WIN_POP;
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_HEAD;
          cmd.out_last = status.fill_one;
          if (status.fill_one) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `SSR_ASSERT_IMPL(a_load_free, cmd.out_load, status.out_free, "output word overwritten")
  `SSR_ASSERT_IMPL(a_flush_nonempty, state == ST_FLUSH, !status.fill_zero, "flush with empty window")
  `SSR_ASSERT_IMPL(a_repl_nonempty, state == ST_REPL, !status.rlen_zero, "replace with empty text")

endmodule

`default_nettype wire

### src/stream_substring_replace.sv
// A result word is registered and shown in the cycle after the word that causes it is accepted.
// One input word per cycle while the sink takes each result, no match with a longer
// than one-byte replacement fires and no string ends with bytes held; the REPL and FLUSH
// states emit the replacement or held bytes in turn. The window holds up to pattern length - 1 bytes.
// Reset: synchronous; clears window fill, controller and output valid, restores registers.
`default_nettype none

module stream_substring_replace #(
  parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = ssr_pkg::REPLACE_MAX_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ssr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ssr_pkg::DATA_W-1:0] pwdata,
  output logic      [ssr_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  input  wire logic                       item_valid,
  output logic                            item_ready,
  input  wire logic [7:0]                 in_byte,
  input  wire logic                       carries_byte,
  input  wire logic                       end_of_string,
  output logic                            result_valid,
  input  wire logic                       result_ready,
  output logic [7:0]                      out_byte,
  output logic                            out_valid,
  output logic                            out_last
);
  import ssr_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  ssr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ssr_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .carries_byte  (carries_byte),
    .end_of_string (end_of_string),
    .status        (status),
    .cmd           (cmd),
    .item_ready    (item_ready)
  );

  ssr_dp #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .result_ready  (result_ready),
    .status        (status),
    .result_valid  (result_valid),
    .out_byte      (out_byte),
    .out_valid     (out_valid),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

### verif/stream_substring_replace_checker.sv
`timescale 1ns / 1ps
// Checker for stream_substring_replace: follows the register port and both word
// channels, predicts every result word and compares it. Depends on ssr_pkg.

module stream_substring_replace_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ssr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ssr_pkg::DATA_W-1:0] pwdata,
  input  wire logic                       pready,
  input  wire logic                       item_valid,
  input  wire logic                       item_ready,
  input  wire logic [7:0]                 in_byte,
  input  wire logic                       carries_byte,
  input  wire logic                       end_of_string,
  input  wire logic                       result_valid,
  input  wire logic                       result_ready,
  input  wire logic [7:0]                 out_byte,
  input  wire logic                       out_valid,
  input  wire logic                       out_last,
  output int unsigned                     fail_count,
  output int unsigned                     words_due
);
  import ssr_pkg::*;

  localparam int MAX_BURST = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } out_word_t;

  logic [63:0] pat_bytes;
  logic [3:0]  pat_len;
  logic [63:0] rep_bytes;
  logic [3:0]  rep_len;
  logic [7:0]  held [PATTERN_MAX_DEF];
  int unsigned held_count;

  out_word_t expected_text[$];
  out_word_t burst[$];
  out_word_t want;

  function automatic void emit(input logic [7:0] data, input logic valid);
    out_word_t w;
    if (burst.size() < MAX_BURST) begin
      w.data  = data;
      w.valid = valid;
      w.last  = 1'b0;
      burst.push_back(w);
    end
  endfunction

  function automatic void shift_out_oldest();
    if (held_count != 0) begin
      emit(held[0], 1'b1);
      for (int i = 0; i < PATTERN_MAX_DEF - 1; i++) held[i] = held[i + 1];
      held_count--;
    end
  endfunction

  // One source word: slide it into the window, replace on a full match,
  // otherwise pass the oldest byte on; flush the window at end of string.
  function automatic void absorb_word(input logic [7:0] data, input logic has_byte,
                                      input logic at_end);
    int unsigned plen;
    int unsigned rlen;
    logic        hit;
    plen = (pat_len == 4'd0) ? 1 : (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : pat_len;
    rlen = (rep_len > REPLACE_MAX_DEF) ? REPLACE_MAX_DEF : rep_len;
    burst.delete();
    if (has_byte) begin
      if (held_count < PATTERN_MAX_DEF) begin
        held[held_count] = data;
        held_count++;
      end
      if (held_count >= plen) begin
        hit = 1'b1;
        for (int i = 0; i < plen; i++)
          if (held[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          for (int i = 0; i < rlen; i++) emit(rep_bytes[8*i +: 8], 1'b1);
          held_count = 0;
        end else begin
          shift_out_oldest();
        end
      end
    end
    if (at_end) begin
      while (held_count != 0) shift_out_oldest();
      // nothing left to carry the end: send a bare marker
      if (burst.size() == 0) emit(8'h00, 1'b0);
      burst[burst.size() - 1].last = 1'b1;
    end
    foreach (burst[k]) expected_text.push_back(burst[k]);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pat_bytes  = '0;
      pat_len    = 4'd1;
      rep_bytes  = '0;
      rep_len    = 4'd0;
      held_count = 0;
      fail_count = 0;
      expected_text.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected result word: out_byte %02h out_valid %0b out_last %0b",
                 out_byte, out_valid, out_last);
          fail_count++;
        end else begin
          want = expected_text.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
            fail_count++;
          end
          if (out_valid !== want.valid) begin
            $error("out_valid: expected %0b, got %0b", want.valid, out_valid);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_last);
            fail_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          REG_PATTERN_BYTES:      pat_bytes = pwdata;
          REG_PATTERN_LENGTH: begin
            // a new length drops whatever the window holds
            pat_len    = pwdata[3:0];
            held_count = 0;
          end
          REG_REPLACEMENT_BYTES:  rep_bytes = pwdata;
          REG_REPLACEMENT_LENGTH: rep_len   = pwdata[3:0];
          default: ;
        endcase
      end
      if (item_valid && item_ready) absorb_word(in_byte, carries_byte, end_of_string);
    end
    words_due = expected_text.size();
  end

endmodule

### verif/stream_substring_replace_tb.sv
`timescale 1ns / 1ps
// Top of the stream_substring_replace testbench: clock, reset, register writes,
// source words and sink stalls. Depends on ssr_pkg and the checker module.

module stream_substring_replace_tb;
  import ssr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_WORDS    = 16;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ADDR_W-1:0]   paddr         = '0;
  logic [DATA_W-1:0]   pwdata        = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                item_valid    = 1'b0;
  logic                item_ready;
  logic [7:0]          in_byte       = 8'h00;
  logic                carries_byte  = 1'b0;
  logic                end_of_string = 1'b0;
  logic                result_valid;
  logic                result_ready  = 1'b0;
  logic [7:0]          out_byte;
  logic                out_valid;
  logic                out_last;

  int unsigned fail_count;
  int unsigned words_due;
  logic        item_taken   = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned words_sent   = 0;

  // stimulus shaping follows the programmed pattern
  logic [63:0] shape_pat  = '0;
  int unsigned shape_plen = 1;
  logic        src_steady   = 1'b0;
  int unsigned src_run_left = 0;
  logic        sink_steady   = 1'b0;
  int unsigned sink_run_left = 0;
  int unsigned sink_stall    = 0;

  stream_substring_replace dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .in_byte       (in_byte),
    .carries_byte  (carries_byte),
    .end_of_string (end_of_string),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .out_byte      (out_byte),
    .out_valid     (out_valid),
    .out_last      (out_last)
  );

  stream_substring_replace_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .in_byte       (in_byte),
    .carries_byte  (carries_byte),
    .end_of_string (end_of_string),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .out_byte      (out_byte),
    .out_valid     (out_valid),
    .out_last      (out_last),
    .fail_count    (fail_count),
    .words_due     (words_due)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    item_taken <= item_valid && item_ready;
    if ((item_valid && item_ready) || (result_valid && result_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("stream_substring_replace test failed");
      $finish;
    end
  end

  // mostly no pause, some short ones, a few long ones
  function automatic int unsigned draw_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  always @(negedge clk) begin
    if (sink_run_left == 0) begin
      sink_steady   = ($urandom_range(0, 3) == 0);
      sink_run_left = $urandom_range(20, 80);
    end
    sink_run_left--;
    if (sink_stall != 0) begin
      result_ready <= 1'b0;
      sink_stall--;
    end else begin
      result_ready <= 1'b1;
      if (!sink_steady) sink_stall = draw_pause();
    end
  end

  task automatic send_item(input logic [7:0] data, input logic has_byte, input logic at_end);
    int unsigned gap;
    if (src_run_left == 0) begin
      src_steady   = ($urandom_range(0, 2) == 0);
      src_run_left = $urandom_range(10, 30);
    end
    src_run_left--;
    gap = src_steady ? 0 : draw_pause();
    if (gap != 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid    = 1'b1;
    in_byte       = data;
    carries_byte  = has_byte;
    end_of_string = at_end;
    do @(negedge clk); while (!item_taken);
    if (has_byte || at_end) words_sent++;
  endtask

  // drain all expected words, then give the block time to go idle
  task automatic settle();
    item_valid = 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic program_setting(input logic [63:0] pat, input logic [3:0] plen,
                                 input logic [63:0] rep, input logic [3:0] rlen);
    settle();
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_PATTERN_LENGTH, {60'd0, plen});
    write_reg(REG_REPLACEMENT_BYTES, rep);
    write_reg(REG_REPLACEMENT_LENGTH, {60'd0, rlen});
    shape_pat  = pat;
    shape_plen = (plen == 4'd0) ? 1 : (plen > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : plen;
  endtask

  // Build a string rich in whole and broken occurrences of the pattern.
  task automatic send_random_string();
    logic [7:0]  text[$];
    int unsigned target;
    int unsigned cut;
    int unsigned pick;
    logic        end_alone;
    target = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 14);
    while (text.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        for (int i = 0; i < shape_plen; i++) text.push_back(shape_pat[8*i +: 8]);
      end else if (pick < 45) begin
        cut = $urandom_range(0, shape_plen - 1);
        for (int i = 0; i < cut; i++) text.push_back(shape_pat[8*i +: 8]);
      end else if (pick < 75) begin
        text.push_back(shape_pat[8*$urandom_range(0, shape_plen - 1) +: 8]);
      end else begin
        text.push_back(8'($urandom));
      end
    end
    end_alone = (text.size() == 0) || ($urandom_range(0, 4) == 0);
    foreach (text[i]) begin
      // stray word with neither byte nor end mark: must be ignored
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(text[i], 1'b1, !end_alone && (i == text.size() - 1));
    end
    if (end_alone) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    logic [63:0] pat;
    logic [63:0] rep;
    logic [3:0]  plen;
    logic [3:0]  rlen;
    int unsigned r;
    int unsigned goal;

    repeat (3) @(negedge clk);
    rst = 1'b0;

    // reset setting: pattern is a single zero byte, replacement empty
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);

    // zero pattern length acts as one, oversized replacement length as the maximum
    program_setting(64'h1234_5678_9ABC_DEFF, 4'd0, 64'h0123_4567_89AB_CDEF, 4'd15);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    // oversized pattern length acts as the maximum
    program_setting(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'h0, 4'd8);
    repeat (7) send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFE, 1'b1, 1'b1);

    // rewrite the pattern length with a partial match held
    program_setting(64'h0000_0000_0063_6261, 4'd3, 64'h58, 4'd1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    settle();
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    send_item(8'h63, 1'b1, 1'b1);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if ($urandom_range(0, 2) == 0) begin
        for (int i = 0; i < 8; i++) pat[8*i +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
      end else begin
        pat = {$urandom, $urandom};
      end
      rep = {$urandom, $urandom};
      r   = $urandom_range(0, 99);
      if (phase == 0) begin
        plen = 4'd8;
        rlen = 4'd8;
      end else if (phase == 1) begin
        plen = 4'd1;
        rlen = 4'd0;
      end else begin
        plen = (r < 10) ? 4'($urandom_range(9, 15)) : (r < 15) ? 4'd0
                                                    : 4'($urandom_range(1, 8));
        rlen = (r < 80) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
      end
      program_setting(pat, plen, rep, rlen);
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal) send_random_string();
    end

    settle();
    if (fail_count == 0 && words_due == 0) begin
      $display("stream_substring_replace test passed");
    end else begin
      $display("stream_substring_replace test failed");
    end
    $finish;
  end

endmodule
